// File: rtl/core/thg_pkg.sv
package thg_pkg;

    localparam int TEMP_W  = 8;
    localparam int THR_W   = 9;   // sanitized thresholds reach 265
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 16;
    localparam int LVL_W   = 2;
    localparam int PROF_W  = 2;
    localparam int ST_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd0;
    localparam logic [LVL_W-1:0] LVL_WARM   = 2'd1;
    localparam logic [LVL_W-1:0] LVL_HOT    = 2'd2;
    localparam logic [LVL_W-1:0] LVL_CRIT   = 2'd3;

    localparam logic [PROF_W-1:0] PROF_BAL     = 2'd0;
    localparam logic [PROF_W-1:0] PROF_SAVE    = 2'd1;
    localparam logic [PROF_W-1:0] PROF_PERF    = 2'd2;
    localparam logic [PROF_W-1:0] PROF_INVALID = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_DENIED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WARM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 2'd3;

    localparam logic [TEMP_W-1:0] WARM_DEFAULT = 8'd75;
    localparam logic [TEMP_W-1:0] HOT_DEFAULT  = 8'd85;
    localparam logic [TEMP_W-1:0] CRIT_DEFAULT = 8'd95;
    localparam logic [HOLD_W-1:0] HOLD_DEFAULT = 16'd10000;
    localparam logic [THR_W-1:0]  THR_GAP      = 9'd5;

    typedef struct packed {
        logic [TEMP_W-1:0] warm;
        logic [TEMP_W-1:0] hot;
        logic [TEMP_W-1:0] crit;
    } t_thresholds;

endpackage

// File: rtl/core/thg_classify.sv
module thg_classify (
    input  thg_pkg::t_thresholds          i_thr,
    input  logic [thg_pkg::TEMP_W-1:0]    i_temp,
    output logic [thg_pkg::LVL_W-1:0]     o_level
);

    logic [thg_pkg::THR_W-1:0] w;
    logic [thg_pkg::THR_W-1:0] h;
    logic [thg_pkg::THR_W-1:0] c;
    logic [thg_pkg::THR_W-1:0] t;

    always_comb begin
        // zero warm falls back to the default; hot and critical keep a gap
        w = (i_thr.warm == '0) ? {1'b0, thg_pkg::WARM_DEFAULT} : {1'b0, i_thr.warm};
        h = ({1'b0, i_thr.hot} <= w) ? w + thg_pkg::THR_GAP : {1'b0, i_thr.hot};
        c = ({1'b0, i_thr.crit} <= h) ? h + thg_pkg::THR_GAP : {1'b0, i_thr.crit};
        t = {1'b0, i_temp};
        if (t < w) begin
            o_level = thg_pkg::LVL_NORMAL;
        end else if (t < h) begin
            o_level = thg_pkg::LVL_WARM;
        end else if (t < c) begin
            o_level = thg_pkg::LVL_HOT;
        end else begin
            o_level = thg_pkg::LVL_CRIT;
        end
    end

endmodule

// File: rtl/core/thermal_threshold_governor_unit.sv
// Thermal threshold governor. Each request is either a sample tick (CPU/GPU
// temperatures plus a millisecond timestamp) or a profile request, and gives
// exactly one result: thermal level, active profile, change flags, request
// status and the shutdown flag. Requests are taken one per clock while
// o_in_stall is low; a request is held in the input register, then its result
// is computed and registered in the result register, and the sustained rate
// is one request per cycle while the downstream does not stall. The
// level/profile state is updated in the same cycle the result register loads,
// which is what lets the next request follow at once.
// The output register holds while the downstream stalls; the input register
// then holds too and back-pressure reaches i_in_valid's side through
// o_in_stall. Thresholds are sanitized at every use: warm 0 means 75, hot
// not above warm means warm+5, critical not above hot means hot+5. Write the
// configuration only while the block is idle.
module thermal_threshold_governor_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [thg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [thg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic                              i_cpu_valid,
    input  logic [thg_pkg::TEMP_W-1:0]        i_proc_temp,
    input  logic                              i_gpu_valid,
    input  logic [thg_pkg::TEMP_W-1:0]        i_gfx_temp,
    input  logic [thg_pkg::TIME_W-1:0]        i_now_ms,
    input  logic [thg_pkg::PROF_W-1:0]        i_requested_profile,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [thg_pkg::LVL_W-1:0]         o_thermal_level,
    output logic [thg_pkg::PROF_W-1:0]        o_profile,
    output logic                              o_level_changed,
    output logic                              o_profile_changed,
    output logic [thg_pkg::ST_W-1:0]          o_request_status,
    output logic                              o_shutdown
);

    // configuration registers
    thg_pkg::t_thresholds               r_thr;
    logic [thg_pkg::HOLD_W-1:0]         r_hold;

    // governor state
    logic [thg_pkg::LVL_W-1:0]          r_level,   n_level;
    logic [thg_pkg::PROF_W-1:0]         r_prof,    n_prof;
    logic [thg_pkg::TIME_W-1:0]         r_start,   n_start;
    logic                               r_timing,  n_timing;

    // input register
    logic                               r_in_valid;
    logic                               r_op;
    logic                               r_cpu_valid;
    logic [thg_pkg::TEMP_W-1:0]         r_proc_temp;
    logic                               r_gpu_valid;
    logic [thg_pkg::TEMP_W-1:0]         r_gfx_temp;
    logic [thg_pkg::TIME_W-1:0]         r_now;
    logic [thg_pkg::PROF_W-1:0]         r_req;

    // result register
    logic                               r_out_valid;
    logic [thg_pkg::LVL_W-1:0]          r_o_level;
    logic [thg_pkg::PROF_W-1:0]         r_o_prof;
    logic                               r_o_lchg,  n_lchg;
    logic                               r_o_pchg,  n_pchg;
    logic [thg_pkg::ST_W-1:0]           r_o_status, n_status;
    logic                               r_o_sd,    n_sd;

    logic                               advance;
    logic                               accept;
    logic [thg_pkg::TEMP_W-1:0]         temp_max;
    logic [thg_pkg::LVL_W-1:0]          class_level;
    logic [thg_pkg::TIME_W-1:0]         elapsed;

    // Advance the held request into the result register when the slot is
    // free or being taken this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.warm <= thg_pkg::WARM_DEFAULT;
            r_thr.hot  <= thg_pkg::HOT_DEFAULT;
            r_thr.crit <= thg_pkg::CRIT_DEFAULT;
            r_hold     <= thg_pkg::HOLD_DEFAULT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                thg_pkg::CFG_WARM: r_thr.warm <= i_cfg_data[thg_pkg::TEMP_W-1:0];
                thg_pkg::CFG_HOT:  r_thr.hot  <= i_cfg_data[thg_pkg::TEMP_W-1:0];
                thg_pkg::CFG_CRIT: r_thr.crit <= i_cfg_data[thg_pkg::TEMP_W-1:0];
                thg_pkg::CFG_HOLD: r_hold     <= i_cfg_data[thg_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the request payload until it advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= i_op;
            r_cpu_valid <= i_cpu_valid;
            r_proc_temp <= i_proc_temp;
            r_gpu_valid <= i_gpu_valid;
            r_gfx_temp  <= i_gfx_temp;
            r_now       <= i_now_ms;
            r_req       <= i_requested_profile;
        end
    end

    // Hottest valid reading; with one valid reading take it alone.
    always_comb begin
        if (r_cpu_valid && r_gpu_valid) begin
            temp_max = (r_proc_temp > r_gfx_temp) ? r_proc_temp : r_gfx_temp;
        end else if (r_cpu_valid) begin
            temp_max = r_proc_temp;
        end else begin
            temp_max = r_gfx_temp;
        end
    end

    thg_classify u_classify (
        .i_thr   (r_thr),
        .i_temp  (temp_max),
        .o_level (class_level)
    );

    always_comb begin
        n_level  = r_level;
        n_prof   = r_prof;
        n_start  = r_start;
        n_timing = r_timing;
        n_lchg   = 1'b0;
        n_pchg   = 1'b0;
        n_status = thg_pkg::ST_OK;
        n_sd     = 1'b0;
        elapsed  = '0;
        if (r_op == thg_pkg::OP_TICK) begin
            // a tick with no reading changes nothing
            if (r_cpu_valid || r_gpu_valid) begin
                n_level = class_level;
                if (class_level != r_level) begin
                    n_lchg = 1'b1;
                    if (class_level == thg_pkg::LVL_CRIT) begin
                        // stamp the entry into critical
                        n_start  = r_now;
                        n_timing = 1'b1;
                    end else if (r_level == thg_pkg::LVL_CRIT) begin
                        n_start  = '0;
                        n_timing = 1'b0;
                    end
                end
                if (class_level == thg_pkg::LVL_CRIT) begin
                    // force power save, flag shutdown once the hold has run out
                    if (r_prof != thg_pkg::PROF_SAVE) begin
                        n_prof = thg_pkg::PROF_SAVE;
                        n_pchg = 1'b1;
                    end
                    elapsed = r_now - n_start;
                    n_sd = n_timing && (elapsed >= {{(thg_pkg::TIME_W-thg_pkg::HOLD_W){1'b0}},
                                                    r_hold});
                end else if (class_level == thg_pkg::LVL_HOT &&
                             r_prof == thg_pkg::PROF_PERF) begin
                    // demote performance while hot
                    n_prof = thg_pkg::PROF_BAL;
                    n_pchg = 1'b1;
                end
            end
        end else begin
            if (r_req == thg_pkg::PROF_INVALID) begin
                n_status = thg_pkg::ST_INVALID;
            end else if (r_req == thg_pkg::PROF_PERF &&
                         (r_level == thg_pkg::LVL_HOT || r_level == thg_pkg::LVL_CRIT)) begin
                n_status = thg_pkg::ST_DENIED;
            end else begin
                // apply, even when it equals the active profile
                n_prof = r_req;
                n_pchg = 1'b1;
            end
        end
    end

    // Commit state together with the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= thg_pkg::LVL_NORMAL;
            r_prof   <= thg_pkg::PROF_BAL;
            r_start  <= '0;
            r_timing <= 1'b0;
        end else if (advance) begin
            r_level  <= n_level;
            r_prof   <= n_prof;
            r_start  <= n_start;
            r_timing <= n_timing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_level  <= n_level;
            r_o_prof   <= n_prof;
            r_o_lchg   <= n_lchg;
            r_o_pchg   <= n_pchg;
            r_o_status <= n_status;
            r_o_sd     <= n_sd;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_thermal_level   = r_o_level;
    assign o_profile         = r_o_prof;
    assign o_level_changed   = r_o_lchg;
    assign o_profile_changed = r_o_pchg;
    assign o_request_status  = r_o_status;
    assign o_shutdown        = r_o_sd;

endmodule
